// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of this project.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the clock, muted while reset is asserted.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled on the clock, live through reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/elmc_pkg.sv -----
// Types and constants of the emergency lamp mode controller.
// Depends on nothing; imported by every module of the block.
package elmc_pkg;

    // Mode codes as shown on the result beat
    typedef enum logic [1:0] {
        MODE_ON    = 2'd0,
        MODE_OFF   = 2'd1,
        MODE_EMERG = 2'd2,
        MODE_SLEEP = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_EMERG_DURATION  = 3'd0,
        CFG_SAMPLE_INTERVAL = 3'd1,
        CFG_SHORT_PRESS     = 3'd2,
        CFG_LONG_PRESS      = 3'd3,
        CFG_LEVEL1          = 3'd4,
        CFG_LEVEL2          = 3'd5,
        CFG_LEVEL3          = 3'd6,
        CFG_LEVEL4          = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned DUR_W      = 20;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned ADC_W      = 12;
    localparam int unsigned SAMPLE_W   = 13;
    localparam int unsigned BARS_W     = 3;

    // Register values after reset
    localparam logic [DUR_W-1:0] RST_EMERG_DURATION  = 20'd600000;
    localparam logic [MS_W-1:0]  RST_SAMPLE_INTERVAL = 16'd10000;
    localparam logic [MS_W-1:0]  RST_SHORT_PRESS     = 16'd50;
    localparam logic [MS_W-1:0]  RST_LONG_PRESS      = 16'd1500;
    localparam logic [ADC_W-1:0] RST_LEVEL1          = 12'd829;
    localparam logic [ADC_W-1:0] RST_LEVEL2          = 12'd878;
    localparam logic [ADC_W-1:0] RST_LEVEL3          = 12'd927;
    localparam logic [ADC_W-1:0] RST_LEVEL4          = 12'd976;

    localparam logic [BARS_W-1:0] BARS_MAX = 3'd4;

    // Input beat
    typedef struct packed {
        logic                tick;
        logic                key_down;
        logic                power_high;
        logic [SAMPLE_W-1:0] battery_sample;
    } t_in_item;

    // Result beat
    typedef struct packed {
        t_mode             mode;
        logic              light_on;
        logic              status_led;
        logic [BARS_W-1:0] battery_bars;
        logic              monitor_on;
    } t_out_item;

    // Configuration registers as seen by the control logic
    typedef struct packed {
        logic [DUR_W-1:0] emergency_duration_ms;
        logic [MS_W-1:0]  sample_interval_ms;
        logic [MS_W-1:0]  short_press_ms;
        logic [MS_W-1:0]  long_press_ms;
        logic [ADC_W-1:0] level1_threshold;
        logic [ADC_W-1:0] level2_threshold;
        logic [ADC_W-1:0] level3_threshold;
        logic [ADC_W-1:0] level4_threshold;
    } t_cfg;

    // Decoded battery sample
    typedef struct packed {
        logic              ok;
        logic [ADC_W-1:0]  value;
        logic [BARS_W-1:0] bars;
    } t_gauge;

endpackage

// ----- src/emergency_lamp_mode_controller_core.sv -----
// Emergency lamp mode controller, top level.
// Depends on elmc_pkg, elmc_cfg, elmc_gauge and elmc_step.
//
// Usage:
//   Input channel: one beat per control pass, carrying the millisecond tick,
//   key level, supply level and a battery ADC sample. A beat is taken on a
//   clock edge with i_in_valid high and o_in_stall low.
//   Output channel: exactly one result beat per input beat (mode, light,
//   status LED, battery bars, monitor flag), in order. A result is taken on
//   an edge with o_out_valid high and i_out_stall low.
//   Configuration channel: i_cfg_valid / o_cfg_ready with a register index
//   and data; ready is always high, so every write is taken while valid is high.
//   Write registers only while no result is outstanding.
// Timing: the result of a beat is shown in the cycle after acceptance. A new
//   beat is taken every cycle; the limit is the single result register,
//   so o_in_stall rises only while that register is full and stalled.
// Reset: synchronous, active low. Registers return to their defaults, the
//   lamp comes up in on mode with monitoring enabled, and the result
//   register empties. While the receiver stalls, the result holds steady.
module emergency_lamp_mode_controller_core
    import elmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_gauge    gauge;
    t_out_item result;
    logic      in_accept;
    logic      r_out_valid;
    t_out_item r_out_item;

    // Stall the input only while a held result cannot move on
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    elmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    elmc_gauge u_gauge (
        .i_sample (i_in_item.battery_sample),
        .i_cfg    (cfg),
        .o_gauge  (gauge)
    );

    elmc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .i_gauge  (gauge),
        .o_result (result)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- src/elmc_gauge.sv -----
// Battery gauge: validates an ADC sample and maps it to a bar count.
// Depends on elmc_pkg.
module elmc_gauge
    import elmc_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    output t_gauge              o_gauge
);

    // Reject zero and over-range readings (top bit set); count down from the top threshold
    always_comb begin
        o_gauge.ok    = !i_sample[SAMPLE_W-1] && (|i_sample[ADC_W-1:0]);
        o_gauge.value = i_sample[ADC_W-1:0];
        priority if (i_sample[ADC_W-1:0] >= i_cfg.level4_threshold) begin
            o_gauge.bars = BARS_MAX;
        end else if (i_sample[ADC_W-1:0] >= i_cfg.level3_threshold) begin
            o_gauge.bars = 3'd3;
        end else if (i_sample[ADC_W-1:0] >= i_cfg.level2_threshold) begin
            o_gauge.bars = 3'd2;
        end else if (i_sample[ADC_W-1:0] >= i_cfg.level1_threshold) begin
            o_gauge.bars = 3'd1;
        end else begin
            o_gauge.bars = 3'd0;
        end
    end

endmodule

// ----- src/elmc_cfg.sv -----
// Configuration register file of the lamp controller.
// Depends on elmc_pkg.
module elmc_cfg
    import elmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.emergency_duration_ms <= RST_EMERG_DURATION;
            r_cfg.sample_interval_ms    <= RST_SAMPLE_INTERVAL;
            r_cfg.short_press_ms        <= RST_SHORT_PRESS;
            r_cfg.long_press_ms         <= RST_LONG_PRESS;
            r_cfg.level1_threshold      <= RST_LEVEL1;
            r_cfg.level2_threshold      <= RST_LEVEL2;
            r_cfg.level3_threshold      <= RST_LEVEL3;
            r_cfg.level4_threshold      <= RST_LEVEL4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EMERG_DURATION:  r_cfg.emergency_duration_ms <= i_cfg_data[DUR_W-1:0];
                CFG_SAMPLE_INTERVAL: r_cfg.sample_interval_ms    <= i_cfg_data[MS_W-1:0];
                CFG_SHORT_PRESS:     r_cfg.short_press_ms        <= i_cfg_data[MS_W-1:0];
                CFG_LONG_PRESS:      r_cfg.long_press_ms         <= i_cfg_data[MS_W-1:0];
                CFG_LEVEL1:          r_cfg.level1_threshold      <= i_cfg_data[ADC_W-1:0];
                CFG_LEVEL2:          r_cfg.level2_threshold      <= i_cfg_data[ADC_W-1:0];
                CFG_LEVEL3:          r_cfg.level3_threshold      <= i_cfg_data[ADC_W-1:0];
                CFG_LEVEL4:          r_cfg.level4_threshold      <= i_cfg_data[ADC_W-1:0];
            endcase
        end
    end

endmodule

// ----- src/elmc_step.sv -----
// Mode state machine: state registers and the next-state logic for one beat.
// Depends on elmc_pkg; takes the decoded sample from elmc_gauge.
module elmc_step
    import elmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_gauge    i_gauge,
    output t_out_item o_result
);

    t_mode             r_mode, n_mode;
    logic              r_monitor, n_monitor;
    logic              r_fail, n_fail;
    logic              r_restore, n_restore;
    logic              r_prev_power, n_prev_power;
    logic              r_prev_key, n_prev_key;
    logic [MS_W-1:0]   r_hold, n_hold;
    logic              r_locked, n_locked;
    logic              r_short_armed, n_short_armed;
    logic              r_wake_armed, n_wake_armed;
    logic [MS_W-1:0]   r_scount, n_scount;
    logic [DUR_W-1:0]  r_ecount, n_ecount;
    logic [ADC_W-1:0]  r_battery, n_battery;
    logic [BARS_W-1:0] r_bars, n_bars;
    logic              r_status, n_status;
    logic              r_spending, n_spending;

    logic press_edge;
    logic short_ev;
    logic long_ev;

    // Work out the state after this beat, in the order the loop runs
    always_comb begin
        n_mode        = r_mode;
        n_monitor     = r_monitor;
        n_fail        = r_fail;
        n_restore     = r_restore;
        n_hold        = r_hold;
        n_locked      = r_locked;
        n_short_armed = r_short_armed;
        n_wake_armed  = r_wake_armed;
        n_scount      = r_scount;
        n_ecount      = r_ecount;
        n_battery     = r_battery;
        n_bars        = r_bars;
        n_status      = r_status;
        n_spending    = r_spending;
        short_ev      = 1'b0;
        long_ev       = 1'b0;
        press_edge    = i_item.key_down && !r_prev_key;

        // Latch supply edges outside off mode
        if (r_mode != MODE_OFF && i_item.power_high != r_prev_power) begin
            if (!i_item.power_high) begin
                n_fail = 1'b1;
            end else begin
                n_restore = 1'b1;
            end
        end
        n_prev_power = i_item.power_high;
        n_prev_key   = i_item.key_down;

        // Take a pending sample on entry to on or emergency
        if (r_spending && (r_mode == MODE_ON || r_mode == MODE_EMERG)) begin
            n_spending = 1'b0;
            if (i_gauge.ok) begin
                n_battery = i_gauge.value;
                n_bars    = i_gauge.bars;
            end
        end

        unique case (r_mode)
            MODE_ON: begin
                // Key scan on the millisecond tick
                if (i_item.tick) begin
                    if (i_item.key_down) begin
                        if (!n_locked) begin
                            if (n_hold != '1) begin
                                n_hold = n_hold + 16'd1;
                            end
                            if (n_hold >= i_cfg.long_press_ms) begin
                                n_short_armed = 1'b0;
                                n_locked      = 1'b1;
                                long_ev       = 1'b1;
                            end else if (n_hold >= i_cfg.short_press_ms) begin
                                n_short_armed = 1'b1;
                            end
                        end
                    end else begin
                        if (n_short_armed) begin
                            n_short_armed = 1'b0;
                            short_ev      = 1'b1;
                        end
                        n_hold   = '0;
                        n_locked = 1'b0;
                    end
                    if (n_scount != '1) begin
                        n_scount = n_scount + 16'd1;
                    end
                end
                // Short press toggles monitoring
                if (short_ev) begin
                    n_monitor = !n_monitor;
                    n_status  = n_monitor;
                    if (!n_monitor) begin
                        n_fail = 1'b0;
                    end
                end
                if (long_ev) begin
                    n_mode       = MODE_OFF;
                    n_status     = 1'b0;
                    n_bars       = '0;
                    n_hold       = '0;
                    n_wake_armed = 1'b0;
                end else if (n_fail && n_monitor) begin
                    n_fail     = 1'b0;
                    n_mode     = MODE_EMERG;
                    n_ecount   = '0;
                    n_scount   = '0;
                    n_spending = 1'b1;
                end else if (n_scount >= i_cfg.sample_interval_ms) begin
                    n_scount = '0;
                    if (i_gauge.ok) begin
                        n_battery = i_gauge.value;
                        n_bars    = i_gauge.bars;
                    end
                end
            end
            MODE_EMERG: begin
                if (i_item.tick) begin
                    if (n_ecount != '1) begin
                        n_ecount = n_ecount + 20'd1;
                    end
                    if (n_scount != '1) begin
                        n_scount = n_scount + 16'd1;
                    end
                end
                if (n_scount >= i_cfg.sample_interval_ms) begin
                    n_scount = '0;
                    if (i_gauge.ok) begin
                        n_battery = i_gauge.value;
                        n_bars    = i_gauge.bars;
                    end
                end
                // End on timeout or low battery
                if (n_ecount >= i_cfg.emergency_duration_ms ||
                    n_battery < i_cfg.level1_threshold) begin
                    if (n_restore) begin
                        n_mode        = MODE_ON;
                        n_monitor     = 1'b1;
                        n_status      = 1'b1;
                        n_fail        = 1'b0;
                        n_restore     = 1'b0;
                        n_hold        = '0;
                        n_locked      = 1'b0;
                        n_short_armed = 1'b0;
                        n_wake_armed  = 1'b0;
                        n_scount      = '0;
                        n_spending    = 1'b1;
                    end else begin
                        n_mode       = MODE_SLEEP;
                        n_status     = 1'b0;
                        n_bars       = '0;
                        n_hold       = '0;
                        n_wake_armed = 1'b0;
                        n_fail       = 1'b0;
                        n_restore    = 1'b0;
                    end
                end
            end
            MODE_SLEEP: begin
                // Wake when the supply is back
                if (i_item.power_high || n_restore) begin
                    n_mode        = MODE_ON;
                    n_monitor     = 1'b1;
                    n_status      = 1'b1;
                    n_fail        = 1'b0;
                    n_restore     = 1'b0;
                    n_hold        = '0;
                    n_locked      = 1'b0;
                    n_short_armed = 1'b0;
                    n_wake_armed  = 1'b0;
                    n_scount      = '0;
                    n_spending    = 1'b1;
                end
            end
            MODE_OFF: begin
                // Arm on a fresh press, turn on after the long hold
                if (press_edge) begin
                    n_wake_armed = 1'b1;
                    n_hold       = '0;
                end
                if (!i_item.key_down) begin
                    n_wake_armed = 1'b0;
                    n_hold       = '0;
                end else if (n_wake_armed && i_item.tick) begin
                    if (n_hold != '1) begin
                        n_hold = n_hold + 16'd1;
                    end
                    if (n_hold >= i_cfg.long_press_ms) begin
                        n_mode        = MODE_ON;
                        n_monitor     = 1'b1;
                        n_status      = 1'b1;
                        n_fail        = 1'b0;
                        n_restore     = 1'b0;
                        n_hold        = '0;
                        n_locked      = 1'b0;
                        n_short_armed = 1'b0;
                        n_wake_armed  = 1'b0;
                        n_scount      = '0;
                        n_spending    = 1'b1;
                    end
                end
            end
        endcase
    end

    // Result of this beat, taken from the updated state
    assign o_result.mode         = n_mode;
    assign o_result.light_on     = (n_mode == MODE_EMERG);
    assign o_result.status_led   = n_status;
    assign o_result.battery_bars = n_bars;
    assign o_result.monitor_on   = n_monitor;

    // Advance the state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ON;
            r_monitor     <= 1'b1;
            r_fail        <= 1'b0;
            r_restore     <= 1'b0;
            r_prev_power  <= 1'b1;
            r_prev_key    <= 1'b0;
            r_hold        <= '0;
            r_locked      <= 1'b0;
            r_short_armed <= 1'b0;
            r_wake_armed  <= 1'b0;
            r_scount      <= '0;
            r_ecount      <= '0;
            r_battery     <= '0;
            r_bars        <= '0;
            r_status      <= 1'b1;
            r_spending    <= 1'b1;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_monitor     <= n_monitor;
            r_fail        <= n_fail;
            r_restore     <= n_restore;
            r_prev_power  <= n_prev_power;
            r_prev_key    <= n_prev_key;
            r_hold        <= n_hold;
            r_locked      <= n_locked;
            r_short_armed <= n_short_armed;
            r_wake_armed  <= n_wake_armed;
            r_scount      <= n_scount;
            r_ecount      <= n_ecount;
            r_battery     <= n_battery;
            r_bars        <= n_bars;
            r_status      <= n_status;
            r_spending    <= n_spending;
        end
    end

endmodule

// ----- src/elmc_chk.sv -----
// Port-level checker for the lamp controller, bound to the top level.
// Depends on elmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module elmc_chk
    import elmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Lamp lights exactly in emergency mode
    `ASSERT_SYNC(a_light_mode, i_clk, i_rst_n, o_out_valid |-> (o_out_item.light_on == (o_out_item.mode == MODE_EMERG)), "light_on disagrees with mode")

    // Gauge never shows more than four bars
    `ASSERT_SYNC(a_bars_range, i_clk, i_rst_n, o_out_valid |-> (o_out_item.battery_bars <= BARS_MAX), "battery_bars out of range")

    // Dark modes keep status and gauge off
    `ASSERT_SYNC(a_dark_clear, i_clk, i_rst_n, (o_out_valid && (o_out_item.mode == MODE_OFF || o_out_item.mode == MODE_SLEEP)) |-> (!o_out_item.status_led && o_out_item.battery_bars == '0), "dark mode shows status or bars")

    // A stalled result stays put
    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)), "stalled result changed")

    // Reset empties the result register
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind emergency_lamp_mode_controller_core elmc_chk u_elmc_chk (.*);
